@@ rtl/assert_macros.svh @@
// Assertion macros shared by the itemset utility evaluator RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define IUE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle
`define IUE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle
`define IUE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/iue_pkg.sv @@
// Shared constants and codes for the itemset utility evaluator.
// No dependencies; used by the stream interfaces and the top level.
package iue_pkg;

    // Pattern geometry
    localparam int PATTERN_MAX = 4;
    localparam int ID_BITS     = 16;

    // Field widths
    localparam int ID_W     = 16;
    localparam int UTIL_W   = 32;
    localparam int TOTAL_W  = 48;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 3;
    localparam int PMASK_W  = 4;
    localparam int TSUM_W   = UTIL_W + $clog2(PATTERN_MAX + 1);

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = ADDR_W - 2;

    typedef enum logic [IDX_W-1:0] {
        REG_PATTERN_SIZE  = 3'd0,
        REG_POSITIVE_MASK = 3'd1,
        REG_PATTERN_ID_A  = 3'd2,
        REG_PATTERN_ID_B  = 3'd3,
        REG_PATTERN_ID_C  = 3'd4,
        REG_PATTERN_ID_D  = 3'd5
    } reg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_VALID       = 2'd0,
        STATUS_EMPTY       = 2'd1,
        STATUS_NO_POSITIVE = 2'd2
    } eval_status_t;

endpackage

@@ rtl/iue_stream_if.sv @@
// Valid/ready stream interfaces for database elements and evaluation results.
// Depends on iue_pkg for the field widths.
interface iue_elem_if;
    import iue_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   item_id;
    logic [UTIL_W-1:0] item_utility;
    logic              end_of_transaction;
    logic              end_of_database;

    modport source (output valid, item_id, item_utility, end_of_transaction,
                    end_of_database, input ready);
    modport sink   (input valid, item_id, item_utility, end_of_transaction,
                    end_of_database, output ready);
endinterface

interface iue_result_if;
    import iue_pkg::*;

    logic                valid;
    logic                ready;
    logic [TOTAL_W-1:0]  itemset_utility;
    logic [STATUS_W-1:0] eval_status;
    logic                saturated;

    modport source (output valid, itemset_utility, eval_status, saturated, input ready);
    modport sink   (input valid, itemset_utility, eval_status, saturated, output ready);
endinterface

@@ rtl/itemset_utility_evaluator_unit.sv @@
// Itemset utility evaluator: input register, match and accumulate stage, result register.
// Depends on iue_pkg, iue_stream_if.sv and assert_macros.svh.
// A database end passes through the input register and then the result register; it waits
// in the input register while the previous result is untaken. Throughput: one request per cycle
// otherwise, as a database end stalls the input only while the previous result is untaken.
// Reset (rst_n low, asynchronous) clears configuration, accumulators and both valid flags.
`include "assert_macros.svh"

module itemset_utility_evaluator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    iue_elem_if.sink                      elem,
    iue_result_if.source                  result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iue_pkg::ADDR_W-1:0]    paddr,
    input  logic [iue_pkg::DATA_W-1:0]    pwdata,
    output logic [iue_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import iue_pkg::*;

    // Configuration registers
    logic [SIZE_W-1:0]      pattern_size_reg;
    logic [PMASK_W-1:0]     positive_mask_reg;
    logic [ID_W-1:0]        slot_id_reg [PATTERN_MAX];

    // Input stage
    logic                   s1_valid_reg;
    logic [ID_W-1:0]        s1_id_reg;
    logic [UTIL_W-1:0]      s1_util_reg;
    logic                   s1_eot_reg;
    logic                   s1_eod_reg;

    // Accumulation state
    logic [PATTERN_MAX-1:0] seen_reg;
    logic [TSUM_W-1:0]      tsum_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic                   sat_reg;

    // Result register
    logic                   out_valid_reg;
    logic [TOTAL_W-1:0]     out_total_reg;
    eval_status_t           out_status_reg;
    logic                   out_sat_reg;

    logic                   cfg_write;
    reg_index_t             cfg_idx;
    logic                   s1_fire;
    logic [PATTERN_MAX-1:0] active_mask;
    logic [PATTERN_MAX-1:0] hit_mask;
    logic [TSUM_W-UTIL_W-1:0] hit_count;
    logic [PATTERN_MAX-1:0] seen_next;
    logic [TSUM_W-1:0]      util_ext;
    logic [TSUM_W-1:0]      contrib;
    logic [TSUM_W-1:0]      tsum_next;
    logic [TOTAL_W:0]       total_sum;
    logic                   overflow;
    logic [TOTAL_W-1:0]     total_clamped;
    logic                   supported;
    logic [TOTAL_W-1:0]     total_after;
    logic                   sat_after;
    logic [PMASK_W-1:0]     active_pmask;
    eval_status_t           status_next;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_index_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_size_reg  <= '0;
            positive_mask_reg <= '0;
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                slot_id_reg[k] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_PATTERN_SIZE:  pattern_size_reg  <= pwdata[SIZE_W-1:0];
                REG_POSITIVE_MASK: positive_mask_reg <= pwdata[PMASK_W-1:0];
                REG_PATTERN_ID_A,
                REG_PATTERN_ID_B,
                REG_PATTERN_ID_C,
                REG_PATTERN_ID_D:
                begin
                    for (int k = 0; k < PATTERN_MAX; k++)
                    begin
                        if (32'(cfg_idx) == 32'(REG_PATTERN_ID_A) + k)
                        begin
                            slot_id_reg[k] <= pwdata[ID_W-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        prdata = '0;
        case (cfg_idx)
            REG_PATTERN_SIZE:  prdata = DATA_W'(pattern_size_reg);
            REG_POSITIVE_MASK: prdata = DATA_W'(positive_mask_reg);
            REG_PATTERN_ID_A,
            REG_PATTERN_ID_B,
            REG_PATTERN_ID_C,
            REG_PATTERN_ID_D:
            begin
                for (int k = 0; k < PATTERN_MAX; k++)
                begin
                    if (32'(cfg_idx) == 32'(REG_PATTERN_ID_A) + k)
                    begin
                        prdata = DATA_W'(slot_id_reg[k]);
                    end
                end
            end
            default: prdata = '0;
        endcase
    end

    // Advance the input stage unless a result would overwrite an untaken one
    assign s1_fire    = s1_valid_reg && (!s1_eod_reg || !out_valid_reg || result.ready);
    assign elem.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (elem.valid && elem.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem.valid && elem.ready)
        begin
            s1_id_reg   <= elem.item_id;
            s1_util_reg <= elem.item_utility;
            s1_eot_reg  <= elem.end_of_transaction;
            s1_eod_reg  <= elem.end_of_database;
        end
    end

    // Match the element against the active, not yet seen slots; scale the utility by the hits
    always_comb
    begin
        util_ext  = {{(TSUM_W-UTIL_W){s1_util_reg[UTIL_W-1]}}, s1_util_reg};
        hit_count = '0;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            active_mask[k] = (k < 32'(pattern_size_reg));
            hit_mask[k]    = active_mask[k] && !seen_reg[k]
                             && (slot_id_reg[k][ID_BITS-1:0] == s1_id_reg[ID_BITS-1:0]);
            if (hit_mask[k])
            begin
                hit_count = hit_count + (TSUM_W-UTIL_W)'(1);
            end
        end
        contrib = util_ext * TSUM_W'(hit_count);
    end

    assign seen_next = seen_reg | hit_mask;
    assign tsum_next = tsum_reg + contrib;
    assign supported = ((seen_next & active_mask) == active_mask);

    // Add the transaction sum to the running total and clamp
    assign total_sum = {total_reg[TOTAL_W-1], total_reg}
                     + {{(TOTAL_W+1-TSUM_W){tsum_next[TSUM_W-1]}}, tsum_next};
    assign overflow  = (total_sum[TOTAL_W] != total_sum[TOTAL_W-1]);

    always_comb
    begin
        if (!overflow)
        begin
            total_clamped = total_sum[TOTAL_W-1:0];
        end
        else if (total_sum[TOTAL_W])
        begin
            total_clamped = {1'b1, {(TOTAL_W-1){1'b0}}};
        end
        else
        begin
            total_clamped = {1'b0, {(TOTAL_W-1){1'b1}}};
        end
    end

    assign total_after = supported ? total_clamped : total_reg;
    assign sat_after   = sat_reg || (supported && overflow);

    // Classify the pattern for the result
    always_comb
    begin
        active_pmask = '0;
        for (int k = 0; k < PATTERN_MAX && k < PMASK_W; k++)
        begin
            active_pmask[k] = active_mask[k];
        end
        if (active_mask == '0)
        begin
            status_next = STATUS_EMPTY;
        end
        else if ((positive_mask_reg & active_pmask) == '0)
        begin
            status_next = STATUS_NO_POSITIVE;
        end
        else
        begin
            status_next = STATUS_VALID;
        end
    end

    // Update the accumulation state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            tsum_reg  <= '0;
            total_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else if (s1_fire)
        begin
            if (s1_eot_reg || s1_eod_reg)
            begin
                seen_reg <= '0;
                tsum_reg <= '0;
            end
            else
            begin
                seen_reg <= seen_next;
                tsum_reg <= tsum_next;
            end
            if (s1_eod_reg)
            begin
                total_reg <= '0;
                sat_reg   <= 1'b0;
            end
            else if (s1_eot_reg)
            begin
                total_reg <= total_after;
                sat_reg   <= sat_after;
            end
        end
    end

    // Hold the result until the request is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_eod_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_eod_reg)
        begin
            out_status_reg <= status_next;
            if (status_next == STATUS_VALID)
            begin
                out_total_reg <= total_after;
                out_sat_reg   <= sat_after;
            end
            else
            begin
                out_total_reg <= '0;
                out_sat_reg   <= 1'b0;
            end
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.itemset_utility = out_total_reg;
    assign result.eval_status     = out_status_reg;
    assign result.saturated       = out_sat_reg;

    // Checks
    `IUE_ASSERT_IMP(a_status_clears_total,
        out_valid_reg && (out_status_reg != STATUS_VALID),
        (out_total_reg == '0) && !out_sat_reg,
        "error status with nonzero total")
    `IUE_ASSERT_NEXT(a_eod_clears_state, s1_fire && s1_eod_reg,
        (total_reg == '0) && !sat_reg && (seen_reg == '0) && (tsum_reg == '0),
        "state not cleared after database end")
    `IUE_ASSERT_NEXT(a_eod_loads_result, s1_fire && s1_eod_reg, out_valid_reg,
        "database end gave no result")
    `IUE_ASSERT_IMP(a_stall_cause, !elem.ready,
        s1_valid_reg && s1_eod_reg && out_valid_reg && !result.ready,
        "input stalled without a blocked result")

endmodule
